>>> rtl/core/psr_pkg.sv
// Shared codes and defaults for the point, segment and triangle relation block.
`default_nettype none

package psr_pkg;

    // Default coordinate width in bits.
    localparam int COORD_BITS_DEF = 16;

    // Number of orientation lanes that run side by side.
    localparam int LANES = 4;

    // Operation codes.
    localparam logic [1:0] OP_POINT_SEG = 2'd0;
    localparam logic [1:0] OP_POINT_TRI = 2'd1;
    localparam logic [1:0] OP_SEG_SEG   = 2'd2;

    // Relation of a point to a directed segment.
    localparam logic [1:0] REL_ON    = 2'd0;
    localparam logic [1:0] REL_EXT   = 2'd1;
    localparam logic [1:0] REL_RIGHT = 2'd2;
    localparam logic [1:0] REL_LEFT  = 2'd3;

    // Relation of a point to a triangle.
    localparam logic [1:0] TRI_EDGE    = 2'd0;
    localparam logic [1:0] TRI_INSIDE  = 2'd1;
    localparam logic [1:0] TRI_OUTSIDE = 2'd2;

endpackage

`default_nettype wire

>>> rtl/core/point_segment_triangle_relation.sv
// An accepted item reaches o_out_valid through the stages listed below.
// Throughput: one item per cycle unless stalled; each stage holds one item
// and moves on when the stage after it is empty or moving, so empty stages
// keep filling while a finished item waits at the output register.
// Stages: coordinate differences, products, orientation decision, result.
// Reset (synchronous, active low) clears every stage valid bit.
`default_nettype none

module point_segment_triangle_relation #(
    parameter int COORD_BITS = psr_pkg::COORD_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [1:0]                   i_operation,
    input  wire logic signed [COORD_BITS-1:0] i_p0_x,
    input  wire logic signed [COORD_BITS-1:0] i_p0_y,
    input  wire logic signed [COORD_BITS-1:0] i_p1_x,
    input  wire logic signed [COORD_BITS-1:0] i_p1_y,
    input  wire logic signed [COORD_BITS-1:0] i_p2_x,
    input  wire logic signed [COORD_BITS-1:0] i_p2_y,
    input  wire logic signed [COORD_BITS-1:0] i_p3_x,
    input  wire logic signed [COORD_BITS-1:0] i_p3_y,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [1:0]                        o_seg_relation,
    output logic [1:0]                        o_tri_relation,
    output logic                              o_crosses
);

    localparam int CB    = COORD_BITS;
    localparam int DW    = CB + 1;
    localparam int PW    = 2 * DW;
    localparam int SW    = PW + 1;
    localparam int LANES = psr_pkg::LANES;

    // Stage valid bits and operation codes.
    logic       r_v1, r_v2, r_v3, r_v4;
    logic [1:0] r_op1, r_op2, r_op3;
    logic       en1, en2, en3, en4;

    // Endpoints f, t and query q for each lane.
    logic signed [CB-1:0] sel_fx [LANES];
    logic signed [CB-1:0] sel_fy [LANES];
    logic signed [CB-1:0] sel_tx [LANES];
    logic signed [CB-1:0] sel_ty [LANES];
    logic signed [CB-1:0] sel_qx [LANES];
    logic signed [CB-1:0] sel_qy [LANES];

    logic signed [DW-1:0] n_e [LANES][8];
    logic signed [DW-1:0] r_e [LANES][8];
    logic signed [PW-1:0] n_m [LANES][4];
    logic signed [PW-1:0] r_m [LANES][4];
    logic [1:0]           n_rel [LANES];
    logic [1:0]           r_rel [LANES];

    logic [1:0] n_seg, n_tri;
    logic       n_crosses;
    logic       any_on_tri, all_left_tri, any_on_seg, straddle;

    // Each stage moves when it is empty or the next stage moves.
    assign en4        = !r_v4 || i_out_ready;
    assign en3        = !r_v3 || en4;
    assign en2        = !r_v2 || en3;
    assign en1        = !r_v1 || en2;
    assign o_in_ready = en1;
    assign o_out_valid = r_v4;

    // Lane routing. Lanes 0 and 3 test fixed triples for every operation;
    // lanes 1 and 2 take the second segment's view for the segment test.
    always_comb begin
        sel_fx[0] = i_p0_x; sel_fy[0] = i_p0_y;
        sel_tx[0] = i_p1_x; sel_ty[0] = i_p1_y;
        sel_qx[0] = i_p3_x; sel_qy[0] = i_p3_y;
        sel_fx[3] = i_p0_x; sel_fy[3] = i_p0_y;
        sel_tx[3] = i_p1_x; sel_ty[3] = i_p1_y;
        sel_qx[3] = i_p2_x; sel_qy[3] = i_p2_y;
        case (i_operation)
            psr_pkg::OP_SEG_SEG: begin
                sel_fx[1] = i_p2_x; sel_fy[1] = i_p2_y;
                sel_tx[1] = i_p3_x; sel_ty[1] = i_p3_y;
                sel_qx[1] = i_p0_x; sel_qy[1] = i_p0_y;
                sel_fx[2] = i_p2_x; sel_fy[2] = i_p2_y;
                sel_tx[2] = i_p3_x; sel_ty[2] = i_p3_y;
                sel_qx[2] = i_p1_x; sel_qy[2] = i_p1_y;
            end
            default: begin
                sel_fx[1] = i_p1_x; sel_fy[1] = i_p1_y;
                sel_tx[1] = i_p2_x; sel_ty[1] = i_p2_y;
                sel_qx[1] = i_p3_x; sel_qy[1] = i_p3_y;
                sel_fx[2] = i_p2_x; sel_fy[2] = i_p2_y;
                sel_tx[2] = i_p0_x; sel_ty[2] = i_p0_y;
                sel_qx[2] = i_p3_x; sel_qy[2] = i_p3_y;
            end
        endcase
    end

    // Per-lane arithmetic for the difference, product and orientation stages.
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        logic signed [DW-1:0] fx, fy, tx, ty, qx, qy;
        logic signed [SW-1:0] det, dot;

        assign fx = {sel_fx[g][CB-1], sel_fx[g]};
        assign fy = {sel_fy[g][CB-1], sel_fy[g]};
        assign tx = {sel_tx[g][CB-1], sel_tx[g]};
        assign ty = {sel_ty[g][CB-1], sel_ty[g]};
        assign qx = {sel_qx[g][CB-1], sel_qx[g]};
        assign qy = {sel_qy[g][CB-1], sel_qy[g]};

        // The differences that feed the cross and dot products.
        always_comb begin
            n_e[g][0] = qx - fx;
            n_e[g][1] = ty - fy;
            n_e[g][2] = qy - fy;
            n_e[g][3] = tx - fx;
            n_e[g][4] = tx - qx;
            n_e[g][5] = fx - qx;
            n_e[g][6] = ty - qy;
            n_e[g][7] = fy - qy;
        end

        // Four products, each DW by DW bits.
        always_comb begin
            n_m[g][0] = PW'(r_e[g][0]) * PW'(r_e[g][1]);
            n_m[g][1] = PW'(r_e[g][2]) * PW'(r_e[g][3]);
            n_m[g][2] = PW'(r_e[g][4]) * PW'(r_e[g][5]);
            n_m[g][3] = PW'(r_e[g][6]) * PW'(r_e[g][7]);
        end

        // Orientation from the cross product, with the dot product
        // settling collinear points.
        always_comb begin
            det = SW'(r_m[g][0]) - SW'(r_m[g][1]);
            dot = SW'(r_m[g][2]) + SW'(r_m[g][3]);
            if (det == '0) begin
                n_rel[g] = (!dot[SW-1] && dot != '0) ? psr_pkg::REL_EXT
                                                     : psr_pkg::REL_ON;
            end else begin
                n_rel[g] = det[SW-1] ? psr_pkg::REL_LEFT : psr_pkg::REL_RIGHT;
            end
        end
    end

    // Combine the lane relations into the answer of the operation.
    always_comb begin
        any_on_tri   = (r_rel[0] == psr_pkg::REL_ON) || (r_rel[1] == psr_pkg::REL_ON) ||
                       (r_rel[2] == psr_pkg::REL_ON);
        all_left_tri = (r_rel[0] == psr_pkg::REL_LEFT) && (r_rel[1] == psr_pkg::REL_LEFT) &&
                       (r_rel[2] == psr_pkg::REL_LEFT);
        any_on_seg   = any_on_tri || (r_rel[3] == psr_pkg::REL_ON);
        // In both lane pairs, both relations are sides and they differ.
        straddle     = (r_rel[1][1] && r_rel[2][1] && (r_rel[1][0] ^ r_rel[2][0])) &&
                       (r_rel[3][1] && r_rel[0][1] && (r_rel[3][0] ^ r_rel[0][0]));
        n_seg     = 2'd0;
        n_tri     = 2'd0;
        n_crosses = 1'b0;
        case (r_op3)
            psr_pkg::OP_POINT_SEG: begin
                n_seg = r_rel[0];
            end
            psr_pkg::OP_POINT_TRI: begin
                if (any_on_tri) begin
                    n_tri = psr_pkg::TRI_EDGE;
                end else if (all_left_tri) begin
                    n_tri = psr_pkg::TRI_INSIDE;
                end else begin
                    n_tri = psr_pkg::TRI_OUTSIDE;
                end
            end
            psr_pkg::OP_SEG_SEG: begin
                n_crosses = straddle || any_on_seg;
            end
            default: begin
                n_seg = 2'd0;
            end
        endcase
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_in_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_op1 <= i_operation;
            for (int l = 0; l < LANES; l++) begin
                for (int k = 0; k < 8; k++) begin
                    r_e[l][k] <= n_e[l][k];
                end
            end
        end
        if (en2) begin
            r_op2 <= r_op1;
            for (int l = 0; l < LANES; l++) begin
                for (int k = 0; k < 4; k++) begin
                    r_m[l][k] <= n_m[l][k];
                end
            end
        end
        if (en3) begin
            r_op3 <= r_op2;
            for (int l = 0; l < LANES; l++) begin
                r_rel[l] <= n_rel[l];
            end
        end
        if (en4) begin
            o_seg_relation <= n_seg;
            o_tri_relation <= n_tri;
            o_crosses      <= n_crosses;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/psr_checker.sv
// Port-level checks for the point, segment and triangle relation block.
`default_nettype none

module psr_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic [1:0] o_seg_relation,
    input wire logic [1:0] o_tri_relation,
    input wire logic       o_crosses
);

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A stalled item holds at the output.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_seg_relation) && $stable(o_tri_relation) &&
            $stable(o_crosses))
        else $error("stalled item changed");

    // Only the field of the selected operation can be nonzero.
    a_one_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            $countones({o_seg_relation != 2'd0, o_tri_relation != 2'd0, o_crosses}) <= 1)
        else $error("more than one operation field set");

    // The triangle relation never takes the unused code.
    a_tri_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_tri_relation != 2'd3)
        else $error("bad triangle relation code");

endmodule

bind point_segment_triangle_relation psr_checker u_psr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_seg_relation (o_seg_relation),
    .o_tri_relation (o_tri_relation),
    .o_crosses      (o_crosses)
);

`default_nettype wire
